>>> rtl/core/ppwd_pkg.sv
// Package for the pose pair weighted distance block.
// Holds action codes, register indexes, controller states, unit widths
// and the CORDIC arctangent step table. No dependencies.
package ppwd_pkg;

	typedef enum logic [1:0] {
		ACT_POS   = 2'd0,
		ACT_QUAT  = 2'd1,
		ACT_JOINT = 2'd2,
		ACT_LIMIT = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		REG_ANGULAR_BY_DOT    = 3'd0,
		REG_BOUNDED_MODE      = 3'd1,
		REG_LINEAR_FACTOR     = 3'd2,
		REG_WORKSPACE_FACTOR  = 3'd3,
		REG_JOINTSPACE_FACTOR = 3'd4,
		REG_LINEAR_MAX        = 3'd5,
		REG_ANGULAR_MAX       = 3'd6,
		REG_JOINTS_IN_USE     = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ITEM,
		ST_SQRT_LIN,
		ST_SQRT_JNT,
		ST_DIV,
		ST_ACOS_SQ,
		ST_ACOS_SQRT,
		ST_CORDIC,
		ST_MUL_T,
		ST_MUL_WS1,
		ST_MUL_WS2,
		ST_MUL_J1,
		ST_MUL_J2,
		ST_OUT
	} state_t;

	localparam logic [16:0] Q_ONE = 17'h10000;

	localparam int MUL_AW     = 48;
	localparam int MUL_BW     = 32;
	localparam int MUL_DW     = 4;
	localparam int MUL_DIGITS = MUL_BW / MUL_DW;

	localparam int SQ_RAD_W  = 64;
	localparam int SQ_ROOT_W = SQ_RAD_W / 2;

	localparam int DIV_W  = 32;
	localparam int DIVS_W = 4;

	localparam int CORDIC_STEPS = 20;
	localparam int CX_W         = 36;
	localparam int Z_W          = 24;
	localparam int ANG_W        = 17;

	function automatic logic [18:0] acos_step(input logic [4:0] i);
		logic [18:0] s;
		case (i)
			5'd0:    s = 19'd262144;
			5'd1:    s = 19'd154753;
			5'd2:    s = 19'd81767;
			5'd3:    s = 19'd41506;
			5'd4:    s = 19'd20834;
			5'd5:    s = 19'd10427;
			5'd6:    s = 19'd5215;
			5'd7:    s = 19'd2608;
			5'd8:    s = 19'd1304;
			5'd9:    s = 19'd652;
			5'd10:   s = 19'd326;
			5'd11:   s = 19'd163;
			5'd12:   s = 19'd81;
			5'd13:   s = 19'd41;
			5'd14:   s = 19'd20;
			5'd15:   s = 19'd10;
			5'd16:   s = 19'd5;
			5'd17:   s = 19'd3;
			5'd18:   s = 19'd1;
			5'd19:   s = 19'd1;
			default: s = 19'd0;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/core/ppwd_mul.sv
// Digit-serial unsigned multiplier, one 4-bit digit of the multiplier per cycle.
// Depends on ppwd_pkg for operand widths.
module ppwd_mul (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic [ppwd_pkg::MUL_AW-1:0]                  mcand,
	input  logic [ppwd_pkg::MUL_BW-1:0]                  mplier,
	output logic                                         done,
	output logic [ppwd_pkg::MUL_AW+ppwd_pkg::MUL_BW-1:0] prod
);
	import ppwd_pkg::*;

	localparam int CW = $clog2(MUL_DIGITS);
	localparam int SW = MUL_AW + MUL_DW;

	logic [MUL_AW-1:0] mc_q;
	logic [MUL_AW-1:0] hi_q;
	logic [MUL_BW-1:0] lo_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [SW-1:0]     sum;

	assign sum = SW'(hi_q) + SW'(mc_q) * SW'(lo_q[MUL_DW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MUL_DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= mcand;
			hi_q <= '0;
			lo_q <= mplier;
		end else if (busy_q) begin
			hi_q <= sum[SW-1:MUL_DW];
			lo_q <= {sum[MUL_DW-1:0], lo_q[MUL_BW-1:MUL_DW]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

>>> rtl/core/ppwd_sqrt.sv
// Bit-serial integer square root (floor), one root bit per cycle.
// Depends on ppwd_pkg for widths.
module ppwd_sqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ppwd_pkg::SQ_RAD_W-1:0]    rad,
	output logic                             done,
	output logic [ppwd_pkg::SQ_ROOT_W-1:0]   root
);
	import ppwd_pkg::*;

	localparam int CW = $clog2(SQ_ROOT_W);
	localparam int RW = SQ_ROOT_W + 2;
	localparam int XW = RW + 2;

	logic [SQ_RAD_W-1:0]  rad_q;
	logic [RW-1:0]        rem_q;
	logic [SQ_ROOT_W-1:0] root_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [XW-1:0]        rx;
	logic [XW-1:0]        trial;
	logic                 ge;

	assign rx    = {rem_q, rad_q[SQ_RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = (rx >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(SQ_ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQ_RAD_W-3:0], 2'b00};
			rem_q  <= ge ? RW'(rx - trial) : RW'(rx);
			root_q <= {root_q[SQ_ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> rtl/core/ppwd_div.sv
// Bit-serial restoring divider by a small nonzero divisor.
// Depends on ppwd_pkg for widths.
module ppwd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppwd_pkg::DIV_W-1:0]    dividend,
	input  logic [ppwd_pkg::DIVS_W-1:0]   divisor,
	output logic                          done,
	output logic [ppwd_pkg::DIV_W-1:0]    quot
);
	import ppwd_pkg::*;

	localparam int CW = $clog2(DIV_W);

	logic [DIV_W-1:0]  dq_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVS_W-1:0] rem_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVS_W:0]   rx;
	logic              ge;

	assign rx = {rem_q, dq_q[DIV_W-1]};
	assign ge = (rx >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIVS_W'(rx - {1'b0, dvs_q}) : DIVS_W'(rx);
			dq_q  <= {dq_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dq_q;

endmodule

>>> rtl/core/ppwd_cordic.sv
// Vectoring CORDIC that turns (x, y) into acos(x)/pi in Q1.16 half-turns.
// One rotation step per cycle; depends on ppwd_pkg for the step table.
module ppwd_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppwd_pkg::ANG_W-1:0]    x,
	input  logic [ppwd_pkg::ANG_W-1:0]    y,
	output logic                          done,
	output logic [ppwd_pkg::ANG_W-1:0]    ang
);
	import ppwd_pkg::*;

	localparam int CW = $clog2(CORDIC_STEPS);

	logic signed [CX_W-1:0] cx_q;
	logic signed [CX_W-1:0] cy_q;
	logic signed [Z_W-1:0]  z_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic signed [CX_W-1:0] cx_sh;
	logic signed [CX_W-1:0] cy_sh;
	logic signed [Z_W-1:0]  step;
	logic                   pos;
	logic signed [Z_W-1:0]  r;

	assign cx_sh = cx_q >>> cnt_q;
	assign cy_sh = cy_q >>> cnt_q;
	assign step  = signed'(Z_W'(acos_step(5'(cnt_q))));
	assign pos   = !cy_q[CX_W-1] && (cy_q != '0);
	assign r     = (z_q + Z_W'(8)) >>> 4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cx_q <= signed'(CX_W'({x, 14'b0}));
			cy_q <= signed'(CX_W'({y, 14'b0}));
			z_q  <= '0;
		end else if (busy_q) begin
			if (pos) begin
				cx_q <= cx_q + cy_sh;
				cy_q <= cy_q - cx_sh;
				z_q  <= z_q + step;
			end else begin
				cx_q <= cx_q - cy_sh;
				cy_q <= cy_q + cx_sh;
				z_q  <= z_q - step;
			end
		end
	end

	always_comb begin
		if (r[Z_W-1])
			ang = '0;
		else if (r > Z_W'(Q_ONE))
			ang = Q_ONE;
		else
			ang = r[ANG_W-1:0];
	end

	assign done = done_q;

endmodule

>>> rtl/core/pose_pair_weighted_distance.sv
// Weighted distance between two waypoints: one coordinate-pair item at a time.
// A limit load is taken in idle and leaves the controller there; any other item runs one
// multiplier product. A last item adds two roots, a divide and five products, and its result
// waits in ST_OUT for a free output register; acos mode adds a product, a root and 20 CORDIC steps.
// A new item is taken only in idle, once the one before is through; the serial units are shared.
// Reset clears accumulators and output valid, loads register defaults, limits all ones.
module pose_pair_weighted_distance #(
	parameter int MAX_JOINTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [2:0]         index,
	input  logic signed [31:0] value_a,
	input  logic signed [31:0] value_b,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        distance,
	output logic               infinite,
	output logic [31:0]        linear_part,
	output logic [16:0]        angular_part,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import ppwd_pkg::*;

	localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

	state_t state_q, state_d;
	logic   launch_q;

	logic        abd_q, bnd_q;
	logic [31:0] lf_q, lmax_q;
	logic [16:0] wf_q, jf_q, amax_q;
	logic [3:0]  jiu_q;

	logic [31:0] lim_q [MAX_JOINTS];

	act_t               act_q;
	logic [2:0]         idx_q;
	logic signed [31:0] a_q, b_q;
	logic               last_q;

	logic [63:0]        pos_sum_q, jnt_sum_q;
	logic signed [63:0] dot_q;
	logic               jexc_q;

	logic [31:0] lin_q, jroot_q, jd_q;
	logic [16:0] ang_q, ycor_q;
	logic [47:0] t_q, p1_q, ws_q;
	logic [48:0] jterm_q;
	logic [31:0] dist_q;

	logic        out_valid_q, inf_out_q;
	logic [31:0] dist_out_q, lin_out_q;
	logic [16:0] ang_out_q;

	logic in_acc, out_load;
	logic mul_start, sqrt_start, div_start, cor_start;
	logic mul_done, sqrt_done, div_done, cor_done;
	logic [MUL_AW-1:0]        mul_a;
	logic [MUL_BW-1:0]        mul_b;
	logic [MUL_AW+MUL_BW-1:0] mul_prod;
	logic [SQ_RAD_W-1:0]      sq_rad;
	logic [SQ_ROOT_W-1:0]     sq_root;
	logic [DIV_W-1:0]         div_quot;
	logic [DIVS_W-1:0]        div_dvs;
	logic [ANG_W-1:0]         cor_ang;

	logic signed [32:0] diff;
	logic [32:0]        mag33;
	logic [31:0]        mag, abs_a, abs_b;
	logic               neg;
	logic [63:0]        prod64;
	logic signed [64:0] sprod, dsum;
	logic [64:0]        usum_pos, usum_jnt;
	logic               in_range;
	logic [JW-1:0]      idx_w;
	logic               lim_hit;
	logic [63:0]        dot_mag;
	logic [47:0]        adot48;
	logic [16:0]        adot;
	logic [32:0]        rad33;
	logic [16:0]        wf_c, jf_c, wf_inv, jf_inv;
	logic [48:0]        ws49;
	logic [47:0]        ws_sat;
	logic [64:0]        fsum;
	logic [63:0]        f64;
	logic [47:0]        fsh;
	logic [31:0]        dist_c;
	logic               inf_c;

	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abd_q  <= 1'b1;
			bnd_q  <= 1'b1;
			lf_q   <= 32'h0001_0000;
			wf_q   <= 17'h08000;
			jf_q   <= 17'h08000;
			lmax_q <= 32'hFFFF_FFFF;
			amax_q <= Q_ONE;
			jiu_q  <= 4'd6;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ANGULAR_BY_DOT:    abd_q  <= cfg_data[0];
				REG_BOUNDED_MODE:      bnd_q  <= cfg_data[0];
				REG_LINEAR_FACTOR:     lf_q   <= cfg_data;
				REG_WORKSPACE_FACTOR:  wf_q   <= cfg_data[16:0];
				REG_JOINTSPACE_FACTOR: jf_q   <= cfg_data[16:0];
				REG_LINEAR_MAX:        lmax_q <= cfg_data;
				REG_ANGULAR_MAX:       amax_q <= cfg_data[16:0];
				REG_JOINTS_IN_USE:     jiu_q  <= cfg_data[3:0];
				default:               ;
			endcase
		end
	end

	// joint limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_JOINTS; i++)
				lim_q[i] <= '1;
		end else if (in_acc && act_t'(action) == ACT_LIMIT && 32'(index) < MAX_JOINTS) begin
			lim_q[JW'(index)] <= value_a;
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= (state_d != state_q);
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		mul_start  = 1'b0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		cor_start  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && act_t'(action) != ACT_LIMIT)
					state_d = ST_ITEM;
			end
			ST_ITEM: begin
				mul_start = launch_q;
				if (mul_done)
					state_d = last_q ? ST_SQRT_LIN : ST_IDLE;
			end
			ST_SQRT_LIN: begin
				sqrt_start = launch_q;
				if (sqrt_done)
					state_d = ST_SQRT_JNT;
			end
			ST_SQRT_JNT: begin
				sqrt_start = launch_q;
				if (sqrt_done)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				div_start = launch_q;
				if (div_done)
					state_d = abd_q ? ST_MUL_T : ST_ACOS_SQ;
			end
			ST_ACOS_SQ: begin
				mul_start = launch_q;
				if (mul_done)
					state_d = ST_ACOS_SQRT;
			end
			ST_ACOS_SQRT: begin
				sqrt_start = launch_q;
				if (sqrt_done)
					state_d = ST_CORDIC;
			end
			ST_CORDIC: begin
				cor_start = launch_q;
				if (cor_done)
					state_d = ST_MUL_T;
			end
			ST_MUL_T: begin
				mul_start = launch_q;
				if (mul_done)
					state_d = ST_MUL_WS1;
			end
			ST_MUL_WS1: begin
				mul_start = launch_q;
				if (mul_done)
					state_d = ST_MUL_WS2;
			end
			ST_MUL_WS2: begin
				mul_start = launch_q;
				if (mul_done)
					state_d = ST_MUL_J1;
			end
			ST_MUL_J1: begin
				mul_start = launch_q;
				if (mul_done)
					state_d = ST_MUL_J2;
			end
			ST_MUL_J2: begin
				mul_start = launch_q;
				if (mul_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// item arithmetic
	assign diff     = {b_q[31], b_q} - {a_q[31], a_q};
	assign mag33    = diff[32] ? 33'(-diff) : 33'(diff);
	assign mag      = mag33[31:0];
	assign abs_a    = a_q[31] ? 32'(-a_q) : 32'(a_q);
	assign abs_b    = b_q[31] ? 32'(-b_q) : 32'(b_q);
	assign neg      = a_q[31] ^ b_q[31];
	assign prod64   = mul_prod[63:0];
	assign sprod    = neg ? -signed'({1'b0, prod64}) : signed'({1'b0, prod64});
	assign dsum     = signed'({dot_q[63], dot_q}) + sprod;
	assign usum_pos = {1'b0, pos_sum_q} + {1'b0, prod64};
	assign usum_jnt = {1'b0, jnt_sum_q} + {1'b0, prod64};
	assign in_range = (32'(idx_q) < MAX_JOINTS);
	assign idx_w    = JW'(idx_q);
	assign lim_hit  = in_range && (mag > lim_q[idx_w]);

	// closing arithmetic
	assign dot_mag = dot_q[63] ? 64'(-dot_q) : 64'(dot_q);
	assign adot48  = dot_mag[63:16];
	assign adot    = (adot48 > 48'(Q_ONE)) ? Q_ONE : adot48[16:0];
	assign rad33   = 33'h1_0000_0000 - mul_prod[32:0];
	assign wf_c    = (wf_q > Q_ONE) ? Q_ONE : wf_q;
	assign jf_c    = (jf_q > Q_ONE) ? Q_ONE : jf_q;
	assign wf_inv  = Q_ONE - wf_c;
	assign jf_inv  = Q_ONE - jf_c;
	assign ws49    = {1'b0, p1_q} + 49'(mul_prod[32:16]);
	assign ws_sat  = ws49[48] ? '1 : ws49[47:0];
	assign fsum    = {1'b0, mul_prod[63:0]} + 65'(jterm_q);
	assign f64     = fsum[64] ? '1 : fsum[63:0];
	assign fsh     = f64[63:16];
	assign dist_c  = (|fsh[47:32]) ? '1 : fsh[31:0];
	assign inf_c   = bnd_q && ((lin_q > lmax_q) || (ang_q > amax_q) || jexc_q);
	assign div_dvs = (jiu_q == '0) ? 4'd1 : jiu_q;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		sq_rad = '0;
		case (state_q)
			ST_ITEM: begin
				if (act_q == ACT_QUAT) begin
					mul_a = MUL_AW'(abs_a);
					mul_b = abs_b;
				end else begin
					mul_a = MUL_AW'(mag);
					mul_b = mag;
				end
			end
			ST_SQRT_LIN:  sq_rad = pos_sum_q;
			ST_SQRT_JNT:  sq_rad = jnt_sum_q;
			ST_ACOS_SQ: begin
				mul_a = MUL_AW'(adot);
				mul_b = MUL_BW'(adot);
			end
			ST_ACOS_SQRT: sq_rad = SQ_RAD_W'(rad33);
			ST_MUL_T: begin
				mul_a = MUL_AW'(lin_q);
				mul_b = lf_q;
			end
			ST_MUL_WS1: begin
				mul_a = t_q;
				mul_b = MUL_BW'(wf_c);
			end
			ST_MUL_WS2: begin
				mul_a = MUL_AW'(ang_q);
				mul_b = MUL_BW'(wf_inv);
			end
			ST_MUL_J1: begin
				mul_a = MUL_AW'(jd_q);
				mul_b = MUL_BW'(jf_c);
			end
			ST_MUL_J2: begin
				mul_a = ws_q;
				mul_b = MUL_BW'(jf_inv);
			end
			default: ;
		endcase
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_sum_q <= '0;
			jnt_sum_q <= '0;
			dot_q     <= '0;
			jexc_q    <= 1'b0;
		end else if (out_load) begin
			pos_sum_q <= '0;
			jnt_sum_q <= '0;
			dot_q     <= '0;
			jexc_q    <= 1'b0;
		end else if (state_q == ST_ITEM && mul_done) begin
			case (act_q)
				ACT_POS:
					pos_sum_q <= usum_pos[64] ? '1 : usum_pos[63:0];
				ACT_QUAT: begin
					if (dsum[64] != dsum[63])
						dot_q <= dsum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
					else
						dot_q <= dsum[63:0];
				end
				ACT_JOINT: begin
					jnt_sum_q <= usum_jnt[64] ? '1 : usum_jnt[63:0];
					if (lim_hit)
						jexc_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// item and closing data
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q  <= act_t'(action);
			idx_q  <= index;
			a_q    <= value_a;
			b_q    <= value_b;
			last_q <= last;
		end
		if (state_q == ST_SQRT_LIN && sqrt_done)
			lin_q <= sq_root;
		if (state_q == ST_SQRT_JNT && sqrt_done)
			jroot_q <= sq_root;
		if (state_q == ST_DIV && div_done) begin
			jd_q <= div_quot;
			if (abd_q)
				ang_q <= Q_ONE - adot;
		end
		if (state_q == ST_ACOS_SQRT && sqrt_done)
			ycor_q <= sq_root[16:0];
		if (state_q == ST_CORDIC && cor_done)
			ang_q <= cor_ang;
		if (state_q == ST_MUL_T && mul_done)
			t_q <= mul_prod[63:16];
		if (state_q == ST_MUL_WS1 && mul_done)
			p1_q <= mul_prod[63:16];
		if (state_q == ST_MUL_WS2 && mul_done)
			ws_q <= ws_sat;
		if (state_q == ST_MUL_J1 && mul_done)
			jterm_q <= mul_prod[48:0];
		if (state_q == ST_MUL_J2 && mul_done)
			dist_q <= dist_c;
		if (out_load) begin
			dist_out_q <= inf_c ? '1 : dist_q;
			inf_out_q  <= inf_c;
			lin_out_q  <= lin_q;
			ang_out_q  <= ang_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid    = out_valid_q;
	assign distance     = dist_out_q;
	assign infinite     = inf_out_q;
	assign linear_part  = lin_out_q;
	assign angular_part = ang_out_q;

	ppwd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_a),
		.mplier (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	ppwd_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (sq_rad),
		.done   (sqrt_done),
		.root   (sq_root)
	);

	ppwd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (jroot_q),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot)
	);

	ppwd_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.x      (adot),
		.y      (ycor_q),
		.done   (cor_done),
		.ang    (cor_ang)
	);

	a_inf_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && inf_out_q |-> dist_out_q == 32'hFFFF_FFFF)
		else $error("infinite result without saturated distance");

	a_ang_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ang_out_q <= Q_ONE)
		else $error("angular part above one");

	a_inf_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !bnd_q |=> !inf_out_q)
		else $error("infinite flag outside bounded mode");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == ST_IDLE)
		else $error("closing item did not produce a result");

endmodule

>>> bench/testbench.sv
// Self-checking bench for pose_pair_weighted_distance.
// Drives waypoint pair items and register writes and checks every result against a fixed-point
// predictor held in a small scoreboard class. Depends on ppwd_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
	import ppwd_pkg::*;

	localparam int  NJ          = 8;
	localparam longint CYCLE_CAP = 3000000;

	typedef struct packed {
		logic [31:0] distance;
		logic        infinite;
		logic [31:0] linear_part;
		logic [16:0] angular_part;
	} waypoint_cost_t;

	class cost_scoreboard;
		waypoint_cost_t costs_due[$];
		int  errors;
		bit  by_dot, bounded;
		bit  [31:0] lin_factor, lin_max;
		bit  [16:0] ws_factor, js_factor, ang_max;
		bit  [3:0]  joints;
		bit  [63:0] pos_sum, jnt_sum;
		longint     dot_sum;
		bit         jnt_over;
		bit  [31:0] jnt_limit [NJ];
		int  acos_tab [20] = '{262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608,
			1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

		function new();
			by_dot = 1; bounded = 1; lin_factor = 32'd65536; ws_factor = 17'd32768;
			js_factor = 17'd32768; lin_max = '1; ang_max = 17'd65536; joints = 4'd6;
			pos_sum = 0; jnt_sum = 0; dot_sum = 0; jnt_over = 0; errors = 0;
			foreach (jnt_limit[i]) jnt_limit[i] = '1;
		endfunction

		function void set_reg(cfg_reg_t r, bit [31:0] v);
			case (r)
				REG_ANGULAR_BY_DOT:    by_dot = v[0];
				REG_BOUNDED_MODE:      bounded = v[0];
				REG_LINEAR_FACTOR:     lin_factor = v;
				REG_WORKSPACE_FACTOR:  ws_factor = v[16:0];
				REG_JOINTSPACE_FACTOR: js_factor = v[16:0];
				REG_LINEAR_MAX:        lin_max = v;
				REG_ANGULAR_MAX:       ang_max = v[16:0];
				REG_JOINTS_IN_USE:     joints = v[3:0];
				default:               ;
			endcase
		endfunction

		function bit [63:0] root_floor(bit [63:0] v);
			bit [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else
					r = r >> 1;
				b = b >> 2;
			end
			return r;
		endfunction

		function bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
			return (a > ~b) ? '1 : a + b;
		endfunction

		function bit [63:0] sq_mag(bit [63:0] m);
			return (m >= 64'h1_0000_0000) ? '1 : m * m;
		endfunction

		function bit [16:0] half_turns(bit [63:0] x);
			longint cx, cy, z, nx, ny, r;
			cx = longint'(x) <<< 14;
			cy = longint'(root_floor(64'h1_0000_0000 - x * x)) <<< 14;
			z = 0;
			for (int i = 0; i < 20; i++) begin
				if (cy > 0) begin
					nx = cx + (cy >>> i); ny = cy - (cx >>> i); z = z + acos_tab[i];
				end else begin
					nx = cx - (cy >>> i); ny = cy + (cx >>> i); z = z - acos_tab[i];
				end
				cx = nx; cy = ny;
			end
			r = (z + 8) >>> 4;
			if (r < 0) r = 0;
			if (r > 65536) r = 65536;
			return r[16:0];
		endfunction

		function void note_item(act_t act, bit [2:0] idx, bit [31:0] va, bit [31:0] vb,
				bit lst);
			longint a, b, d, p;
			bit [63:0] mag, lin, ang, adot, jd, wf, jf, t, ws, cost;
			bit inf;
			waypoint_cost_t c;
			a = longint'(signed'(va));
			b = longint'(signed'(vb));
			d = b - a;
			mag = (d < 0) ? -d : d;
			case (act)
				ACT_LIMIT: begin
					jnt_limit[idx] = va;
					return;
				end
				ACT_POS: pos_sum = add_sat(pos_sum, sq_mag(mag));
				ACT_QUAT: begin
					p = a * b;
					if (p > 0 && dot_sum > 64'sh7FFF_FFFF_FFFF_FFFF - p)
						dot_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
					else if (p < 0 && dot_sum < 64'sh8000_0000_0000_0000 - p)
						dot_sum = 64'sh8000_0000_0000_0000;
					else
						dot_sum = dot_sum + p;
				end
				default: begin
					jnt_sum = add_sat(jnt_sum, sq_mag(mag));
					if (mag > jnt_limit[idx]) jnt_over = 1;
				end
			endcase
			if (!lst) return;
			lin = root_floor(pos_sum);
			adot = (dot_sum < 0) ? 64'(-(dot_sum + 1)) + 1 : 64'(dot_sum);
			adot = adot >> 16;
			if (adot > 65536) adot = 65536;
			ang = by_dot ? 65536 - adot : 64'(half_turns(adot));
			jd = root_floor(jnt_sum) / ((joints == 0) ? 64'd1 : 64'(joints));
			wf = (ws_factor > 65536) ? 65536 : ws_factor;
			jf = (js_factor > 65536) ? 65536 : js_factor;
			t = (64'(lin_factor) * lin) >> 16;
			ws = ((t * wf) >> 16) + (((65536 - wf) * ang) >> 16);
			if (ws > 64'hFFFF_FFFF_FFFF) ws = 64'hFFFF_FFFF_FFFF;
			cost = add_sat(jf * jd, (65536 - jf) * ws) >> 16;
			if (cost > 64'hFFFF_FFFF) cost = 64'hFFFF_FFFF;
			inf = bounded && (lin > lin_max || ang > ang_max || jnt_over);
			if (inf) cost = 64'hFFFF_FFFF;
			c.distance = cost[31:0];
			c.infinite = inf;
			c.linear_part = lin[31:0];
			c.angular_part = ang[16:0];
			costs_due = {costs_due, c};
			pos_sum = 0; jnt_sum = 0; dot_sum = 0; jnt_over = 0;
		endfunction

		task report(string what, longint unsigned got, longint unsigned want);
			if (errors < 40)
				$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task check_result(waypoint_cost_t got);
			waypoint_cost_t want;
			if (costs_due.size() == 0) begin
				report("unexpected result, distance", got.distance, 0);
				return;
			end
			want = costs_due.pop_front();
			if (got.distance !== want.distance)
				report("distance", got.distance, want.distance);
			if (got.infinite !== want.infinite)
				report("infinite", got.infinite, want.infinite);
			if (got.linear_part !== want.linear_part)
				report("linear_part", got.linear_part, want.linear_part);
			if (got.angular_part !== want.angular_part)
				report("angular_part", got.angular_part, want.angular_part);
		endtask
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         action = '0;
	logic [2:0]         index = '0;
	logic signed [31:0] value_a = '0;
	logic signed [31:0] value_b = '0;
	logic               last = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [31:0]        distance;
	logic               infinite;
	logic [31:0]        linear_part;
	logic [16:0]        angular_part;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	cost_scoreboard sb = new();
	bit     send_idle = 1, take_idle = 1;
	int     hold_left = 0;
	longint cycles = 0;
	int     items_sent = 0;

	pose_pair_weighted_distance #(.MAX_JOINTS(NJ)) DUT (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result('{distance, infinite, linear_part, angular_part});
		if (hold_left > 0) begin
			out_ready <= 0;
			hold_left--;
		end else
			out_ready <= take_idle ? ($urandom_range(99) >= 18) : 1'b1;
	end

	task write_reg(cfg_reg_t r, bit [31:0] v);
		cfg_valid <= 1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(r, v);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task send_item(act_t act, bit [2:0] idx, bit [31:0] va, bit [31:0] vb, bit lst);
		if (send_idle && $urandom_range(99) < 18) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		action <= act;
		index <= idx;
		value_a <= va;
		value_b <= vb;
		last <= lst;
		do @(posedge clk); while (!in_ready);
		sb.note_item(act, idx, va, vb, lst);
		items_sent++;
	endtask

	task drain;
		in_valid <= 0;
		while (sb.costs_due.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function bit [31:0] coord();
		case ($urandom_range(9))
			0:       return $urandom();
			1:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2, 3:    return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
			default: return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
		endcase
	endfunction

	function bit [31:0] quat();
		if ($urandom_range(19) == 0) return $urandom();
		return 32'(int'($urandom_range(0, 80000)) - 40000);
	endfunction

	function bit [31:0] pick32();
		case ($urandom_range(4))
			0:       return 32'h0;
			1:       return 32'hFFFF_FFFF;
			2:       return $urandom_range(0, 1 << 20);
			default: return $urandom();
		endcase
	endfunction

	function bit [31:0] pick17();
		case ($urandom_range(4))
			0:       return 0;
			1:       return 65536;
			2:       return $urandom_range(65537, 131071);
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	task random_config;
		write_reg(REG_ANGULAR_BY_DOT, $urandom_range(1));
		write_reg(REG_BOUNDED_MODE, $urandom_range(1));
		write_reg(REG_LINEAR_FACTOR, pick32());
		write_reg(REG_WORKSPACE_FACTOR, pick17());
		write_reg(REG_JOINTSPACE_FACTOR, pick17());
		write_reg(REG_LINEAR_MAX, pick32());
		write_reg(REG_ANGULAR_MAX, pick17());
		write_reg(REG_JOINTS_IN_USE, $urandom_range(15));
	endtask

	task load_limits;
		for (int j = 0; j < NJ; j++)
			send_item(ACT_LIMIT, 3'(j),
				$urandom_range(2) ? $urandom_range(0, 1 << 20) : 32'hFFFF_FFFF,
				$urandom(), 1'($urandom_range(1)));
	endtask

	task random_group;
		int n;
		act_t a;
		bit [31:0] va, vb;
		n = $urandom_range(1, 10);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(19))
				0:       a = ACT_LIMIT;
				1, 2, 3, 4, 5, 6: a = ACT_POS;
				7, 8, 9, 10, 11:  a = ACT_QUAT;
				default: a = ACT_JOINT;
			endcase
			if (a == ACT_QUAT) begin
				va = quat(); vb = quat();
			end else if (a == ACT_LIMIT) begin
				va = pick32(); vb = $urandom();
			end else begin
				va = coord(); vb = coord();
			end
			send_item(a, 3'($urandom_range(7)), va, vb,
				k == n - 1 || $urandom_range(30) == 0);
		end
	endtask

	task random_phase(int target);
		int stop_at, pause_at;
		stop_at = items_sent + target;
		pause_at = items_sent + target / 2;
		load_limits();
		while (items_sent < stop_at) begin
			random_group();
			if (items_sent >= pause_at && pause_at != 0) begin
				drain();
				pause_at = 0;
			end
		end
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// extremes with reset registers
		send_item(ACT_POS, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_item(ACT_POS, 7, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_item(ACT_QUAT, 3, 32'h8000_0000, 32'h8000_0000, 0);
		send_item(ACT_QUAT, 5, 32'h8000_0000, 32'h8000_0000, 0);
		send_item(ACT_QUAT, 0, 32'h8000_0000, 32'h8000_0000, 0);
		send_item(ACT_JOINT, 7, 32'h8000_0000, 32'h7FFF_FFFF, 1);
		send_item(ACT_LIMIT, 2, 32'h0, 32'h0, 1);
		send_item(ACT_LIMIT, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_item(ACT_JOINT, 2, 32'h0001_0000, 32'h0001_0000, 0);
		send_item(ACT_QUAT, 1, 32'h0001_0000, 32'h0001_0000, 1);
		send_item(ACT_JOINT, 2, 32'h0, 32'h1, 0);
		send_item(ACT_QUAT, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_item(ACT_QUAT, 2, 32'h8000_0000, 32'h7FFF_FFFF, 1);
		send_item(ACT_POS, 1, 32'h0, 32'h0, 1);
		drain();

		write_reg(REG_ANGULAR_BY_DOT, 0);
		write_reg(REG_BOUNDED_MODE, 0);
		write_reg(REG_LINEAR_FACTOR, 32'hFFFF_FFFF);
		write_reg(REG_WORKSPACE_FACTOR, 17'h1FFFF);
		write_reg(REG_JOINTSPACE_FACTOR, 0);
		write_reg(REG_LINEAR_MAX, 0);
		write_reg(REG_ANGULAR_MAX, 0);
		write_reg(REG_JOINTS_IN_USE, 0);
		send_item(ACT_QUAT, 0, 32'h0000_B505, 32'h0000_B505, 0);
		send_item(ACT_QUAT, 3, 32'h0000_8000, 32'h0000_4000, 1);
		send_item(ACT_QUAT, 0, 32'h0001_0000, 32'hFFFF_0000, 1);
		send_item(ACT_POS, 2, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_item(ACT_JOINT, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1);
		send_item(ACT_QUAT, 1, 32'h0, 32'h0, 1);
		drain();
		write_reg(REG_BOUNDED_MODE, 1);
		write_reg(REG_JOINTS_IN_USE, 15);
		write_reg(REG_JOINTSPACE_FACTOR, 65536);
		send_item(ACT_POS, 0, 32'h0, 32'h1, 1);
		drain();

		// receiver holds off while the sender keeps offering items
		hold_left = 4000;
		random_phase(60);

		// a stretch with no idling on either side
		send_idle = 0;
		take_idle = 0;
		random_config();
		random_phase(200);
		send_idle = 1;
		take_idle = 1;

		while (items_sent < 1550) begin
			random_config();
			random_phase(160);
		end

		drain();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/ppwd_pkg.sv
rtl/core/ppwd_mul.sv
rtl/core/ppwd_sqrt.sv
rtl/core/ppwd_div.sv
rtl/core/ppwd_cordic.sv
rtl/core/pose_pair_weighted_distance.sv
bench/testbench.sv
